// ===== src/assert_macros.svh =====
// Assertion macros shared by the accumulator and flag unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define AF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define AF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/z80af_pkg.sv =====
// Types and constants of the accumulator and flag unit.
package z80af_pkg;

  typedef logic [3:0] op_t;

  localparam op_t OP_DAA    = 4'd0;
  localparam op_t OP_CPL    = 4'd1;
  localparam op_t OP_RLCA   = 4'd2;
  localparam op_t OP_RRCA   = 4'd3;
  localparam op_t OP_RLA    = 4'd4;
  localparam op_t OP_RRA    = 4'd5;
  localparam op_t OP_SCF    = 4'd6;
  localparam op_t OP_CCF    = 4'd7;
  localparam op_t OP_RLD    = 4'd8;
  localparam op_t OP_RRD    = 4'd9;
  localparam op_t OP_CPI    = 4'd10;
  localparam op_t OP_LDI    = 4'd11;
  localparam op_t OP_NOFLAG = 4'd12;
  localparam op_t OP_LOAD   = 4'd13;
  localparam op_t OP_RSV0   = 4'd14;
  localparam op_t OP_RSV1   = 4'd15;

  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;

  // flag byte bit positions: S Z Y H X P N C
  localparam int FL_C = 0;
  localparam int FL_N = 1;
  localparam int FL_P = 2;
  localparam int FL_X = 3;
  localparam int FL_H = 4;
  localparam int FL_Y = 5;
  localparam int FL_Z = 6;
  localparam int FL_S = 7;

  typedef struct packed {
    logic [3:0] op;
    logic [7:0] data;
    logic [7:0] flags_in;
    logic       count_nonzero;
  } in_word_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] flag_byte;
    logic [7:0] mem_byte;
    logic       q_out;
  } out_word_t;

  // decoded command held in the queue
  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [7:0] flags_in;
    logic       count_nonzero;
  } cmd_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// ===== src/z80af_front.sv =====
// Front end: accepts input words and folds unused opcodes into the no-flag operation.
module z80af_front (
  input  logic                     cmd_valid,
  output logic                     cmd_ready,
  input  z80af_pkg::in_word_t      cmd,
  input  z80af_pkg::queue_status_t qstat,
  output logic                     push,
  output z80af_pkg::cmd_t          push_cmd
);
  import z80af_pkg::*;

  op_t op_norm;

  always_comb begin
    unique case (cmd.op) inside
      OP_NOFLAG, OP_RSV0, OP_RSV1: op_norm = OP_NOFLAG;
      default:                      op_norm = cmd.op;
    endcase
  end

  assign cmd_ready              = !qstat.full;
  assign push                   = cmd_valid && !qstat.full;
  assign push_cmd.op            = op_norm;
  assign push_cmd.data          = cmd.data;
  assign push_cmd.flags_in      = cmd.flags_in;
  assign push_cmd.count_nonzero = cmd.count_nonzero;

endmodule

// ===== src/z80af_queue.sv =====
// Short command queue between the front end and the executor.
`include "assert_macros.svh"

module z80af_queue #(
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  z80af_pkg::cmd_t          push_cmd,
  input  logic                     pop,
  output z80af_pkg::cmd_t          pop_cmd,
  output z80af_pkg::queue_status_t qstat
);
  import z80af_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;
  logic          do_push, do_pop;

  assign qstat.full  = (count == FULL_CNT);
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_cmd     = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (do_push) wr_ptr_next = (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
    if (do_pop)  rd_ptr_next = (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
    if (do_push && !do_pop) count_next = count + 1'b1;
    else if (do_pop && !do_push) count_next = count - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_cmd;
  end

  `AF_ASSERT(a_count_bound, clk, rst, count <= FULL_CNT, "queue count above depth")
  `AF_ASSERT(a_push_not_full, clk, rst, push |-> !qstat.full, "word pushed into full queue")
  `AF_ASSERT(a_pop_not_empty, clk, rst, pop |-> !qstat.empty, "pop from empty queue")
  `AF_ASSERT(a_count_track, clk, rst, (do_push && !do_pop) |=> (count == $past(count) + 1'b1),
    "queue count missed a push")

endmodule

// ===== src/z80af_exec.sv =====
// Executor: holds A, F and Q, runs one command per cycle into the result register while the result side accepts.
`include "assert_macros.svh"

module z80af_exec (
  input  logic                     clk,
  input  logic                     rst,
  input  z80af_pkg::queue_status_t qstat,
  input  z80af_pkg::cmd_t          pop_cmd,
  output logic                     pop,
  output logic                     res_valid,
  input  logic                     res_ready,
  output z80af_pkg::out_word_t     res
);
  import z80af_pkg::*;

  logic [7:0] a, a_next;
  logic [7:0] f, f_next;
  logic       q, q_next;
  logic [7:0] mem_next;
  logic       res_valid_next;

  logic [7:0] d;
  logic       c;
  logic [7:0] daa_hi, daa_lo;
  logic       daa_c;
  logic [7:0] cp_n, cp_t, ld_t;
  logic       cp_h;
  logic [7:0] rot;
  logic [7:0] yx_keep;

  assign d   = pop_cmd.data;
  assign c   = f[FL_C];
  assign pop = !qstat.empty && (!res_valid || res_ready);

  always_comb begin
    // decimal adjust: high step, then low step on its result
    daa_c  = c;
    daa_hi = a;
    if (c || (a > DAA_HI_LIMIT)) begin
      daa_hi = f[FL_N] ? a - DAA_HI_ADJ : a + DAA_HI_ADJ;
      daa_c  = 1'b1;
    end
    daa_lo = daa_hi;
    if (f[FL_H] || (daa_hi[3:0] > DAA_LO_LIMIT))
      daa_lo = f[FL_N] ? daa_hi - DAA_LO_ADJ : daa_hi + DAA_LO_ADJ;

    cp_n = a - d;
    cp_h = a[4] ^ d[4] ^ cp_n[4];
    cp_t = cp_n - {7'd0, cp_h};
    ld_t = a + d;

    // X and Y survive SCF/CCF only when Q is clear: the previous op was a load or left flags alone
    yx_keep = q ? 8'h00 : (f & 8'h28);
  end

  always_comb begin
    a_next   = a;
    f_next   = f;
    q_next   = 1'b1;
    mem_next = 8'h00;
    rot      = a;
    unique case (pop_cmd.op)
      OP_DAA: begin
        a_next = daa_lo;
        f_next = {daa_lo[7], daa_lo == 8'h00, daa_lo[5], daa_lo[4] ^ a[4],
                  daa_lo[3], ~^daa_lo, f[FL_N], daa_c};
      end
      OP_CPL: begin
        a_next = ~a;
        f_next = {f[FL_S], f[FL_Z], ~a[5], 1'b1, ~a[3], f[FL_P], 1'b1, c};
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        unique case (pop_cmd.op)
          OP_RLCA: rot = {a[6:0], a[7]};
          OP_RRCA: rot = {a[0], a[7:1]};
          OP_RLA:  rot = {a[6:0], c};
          default: rot = {c, a[7:1]};
        endcase
        a_next = rot;
        f_next = {f[FL_S], f[FL_Z], rot[5], 1'b0, rot[3], f[FL_P], 1'b0,
                  (pop_cmd.op == OP_RLCA || pop_cmd.op == OP_RLA) ? a[7] : a[0]};
      end
      OP_SCF: begin
        f_next = {f[FL_S], f[FL_Z], yx_keep[5] | a[5], 1'b0, yx_keep[3] | a[3],
                  f[FL_P], 1'b0, 1'b1};
      end
      OP_CCF: begin
        f_next = {f[FL_S], f[FL_Z], yx_keep[5] | a[5], c, yx_keep[3] | a[3],
                  f[FL_P], 1'b0, ~c};
      end
      OP_RLD, OP_RRD: begin
        if (pop_cmd.op == OP_RLD) begin
          mem_next = {d[3:0], a[3:0]};
          a_next   = {a[7:4], d[7:4]};
        end else begin
          mem_next = {a[3:0], d[7:4]};
          a_next   = {a[7:4], d[3:0]};
        end
        f_next = {a_next[7], a_next == 8'h00, a_next[5], 1'b0, a_next[3],
                  ~^a_next, 1'b0, c};
      end
      OP_CPI: begin
        f_next = {cp_n[7], cp_n == 8'h00, cp_t[1], cp_h, cp_t[3],
                  pop_cmd.count_nonzero, 1'b1, c};
      end
      OP_LDI: begin
        f_next = {f[FL_S], f[FL_Z], ld_t[1], 1'b0, ld_t[3],
                  pop_cmd.count_nonzero, 1'b0, c};
      end
      OP_LOAD: begin
        a_next = d;
        f_next = pop_cmd.flags_in;
        q_next = 1'b0;
      end
      default: begin
        q_next = 1'b0;
      end
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (pop) res_valid_next = 1'b1;
    else if (res_ready) res_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a         <= 8'h00;
      f         <= 8'h00;
      q         <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
      if (pop) begin
        a <= a_next;
        f <= f_next;
        q <= q_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.acc       <= a_next;
      res.flag_byte <= f_next;
      res.mem_byte  <= mem_next;
      res.q_out     <= q_next;
    end
  end

  `AF_ASSERT(a_pop_fills, clk, rst, pop |=> res_valid, "executed word not presented")
  `AF_ASSERT(a_res_tracks_state, clk, rst, $past(pop) |-> (res.acc == a && res.flag_byte == f
    && res.q_out == q), "result word differs from held state")
  `AF_ASSERT(a_load_clears_q, clk, rst, (pop && pop_cmd.op == OP_LOAD) |=> !q,
    "load left Q set")
  `AF_ASSERT(a_stall_holds_state, clk, rst, !pop |=> ($stable(a) && $stable(f)),
    "state moved without a pop")

endmodule

// ===== src/z80_accumulator_flag_unit.sv =====
// Z80 accumulator and flag unit: front end, command queue and executor.
// An accepted word goes into the queue and is then popped into the result register.
// Throughput: one word per cycle while the result side accepts (single pass over A, F).
// The queue takes up to QUEUE_DEPTH words while the result side stalls.
// Reset (synchronous, active high) clears A, F, Q, the queue and the result valid.
module z80_accumulator_flag_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  z80af_pkg::in_word_t  cmd,
  output logic                 res_valid,
  input  logic                 res_ready,
  output z80af_pkg::out_word_t res
);
  import z80af_pkg::*;

  queue_status_t qstat;
  cmd_t          push_cmd, pop_cmd;
  logic          push, pop;

  z80af_front u_front (
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .qstat     (qstat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  z80af_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .qstat    (qstat)
  );

  z80af_exec u_exec (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ===== verif/tb_top.sv =====
// Testbench for the accumulator and flag unit: directed and random words, checked in order.
module tb_top;
  import z80af_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 80;

  logic       clk;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_ready;
  in_word_t   cmd;
  logic       res_valid;
  logic       res_ready;
  out_word_t  res;

  z80_accumulator_flag_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Model state: A, F and Q, set when the last word was neither a load nor a no-flag word
  logic [7:0] acc_model;
  logic [7:0] flag_model;
  logic       touched_model;

  out_word_t  pending_results[$];
  int         mismatch_count;
  int         cycle_count;
  int         burst_left;
  bit         steady_send;
  int         hold_seq;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] result_flags(input logic [7:0] v);
    logic [7:0] f;
    f = '0;
    f[FL_S] = v[7];
    f[FL_Z] = (v == 8'h00);
    f[FL_Y] = v[5];
    f[FL_X] = v[3];
    f[FL_P] = ~^v;
    return f;
  endfunction

  // Compute the result word of one command and advance the model state.
  function automatic out_word_t apply_acc_op(input in_word_t w);
    logic [7:0] a, fo, f, m, t, n, prior;
    logic       c, q, h;
    out_word_t  r;
    a = acc_model;
    fo = flag_model;
    f = fo;
    m = '0;
    q = 1'b1;
    c = fo[FL_C];
    case (w.op)
      OP_DAA: begin
        prior = a;
        if (c || a > DAA_HI_LIMIT) begin
          a = fo[FL_N] ? a - DAA_HI_ADJ : a + DAA_HI_ADJ;
          c = 1'b1;
        end
        if (fo[FL_H] || a[3:0] > DAA_LO_LIMIT)
          a = fo[FL_N] ? a - DAA_LO_ADJ : a + DAA_LO_ADJ;
        f = result_flags(a);
        f[FL_H] = a[4] ^ prior[4];
        f[FL_N] = fo[FL_N];
        f[FL_C] = c;
      end
      OP_CPL: begin
        a = ~a;
        f[FL_N] = 1'b1;
        f[FL_H] = 1'b1;
        f[FL_Y] = a[5];
        f[FL_X] = a[3];
      end
      OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
        case (w.op)
          OP_RLCA: begin
            t[0] = a[7];
            a = {a[6:0], a[7]};
          end
          OP_RRCA: begin
            t[0] = a[0];
            a = {a[0], a[7:1]};
          end
          OP_RLA: begin
            t[0] = a[7];
            a = {a[6:0], c};
          end
          default: begin
            t[0] = a[0];
            a = {c, a[7:1]};
          end
        endcase
        f[FL_Y] = a[5];
        f[FL_X] = a[3];
        f[FL_H] = 1'b0;
        f[FL_N] = 1'b0;
        f[FL_C] = t[0];
      end
      OP_SCF, OP_CCF: begin
        // drop the old X and Y when the previous word set Q (any word but a load or a no-flag word)
        f[FL_Y] = (touched_model ? 1'b0 : fo[FL_Y]) | a[5];
        f[FL_X] = (touched_model ? 1'b0 : fo[FL_X]) | a[3];
        f[FL_N] = 1'b0;
        if (w.op == OP_SCF) begin
          f[FL_H] = 1'b0;
          f[FL_C] = 1'b1;
        end else begin
          f[FL_H] = c;
          f[FL_C] = ~c;
        end
      end
      OP_RLD, OP_RRD: begin
        if (w.op == OP_RLD) begin
          m = {w.data[3:0], a[3:0]};
          a = {a[7:4], w.data[7:4]};
        end else begin
          m = {a[3:0], w.data[7:4]};
          a = {a[7:4], w.data[3:0]};
        end
        f = result_flags(a);
        f[FL_C] = c;
      end
      OP_CPI: begin
        n = a - w.data;
        h = a[4] ^ w.data[4] ^ n[4];
        t = n - {7'd0, h};
        f = '0;
        f[FL_S] = n[7];
        f[FL_Z] = (n == 8'h00);
        f[FL_H] = h;
        f[FL_X] = t[3];
        f[FL_Y] = t[1];
        f[FL_P] = w.count_nonzero;
        f[FL_N] = 1'b1;
        f[FL_C] = c;
      end
      OP_LDI: begin
        t = a + w.data;
        f[FL_X] = t[3];
        f[FL_Y] = t[1];
        f[FL_P] = w.count_nonzero;
        f[FL_H] = 1'b0;
        f[FL_N] = 1'b0;
      end
      OP_LOAD: begin
        a = w.data;
        f = w.flags_in;
        q = 1'b0;
      end
      default: q = 1'b0;
    endcase
    acc_model = a;
    flag_model = f;
    touched_model = q;
    r.acc = a;
    r.flag_byte = f;
    r.mem_byte = m;
    r.q_out = q;
    return r;
  endfunction

  function automatic in_word_t make_word(input op_t op, input logic [7:0] data,
                                         input logic [7:0] flags, input logic cnz);
    in_word_t w;
    w.op = op;
    w.data = data;
    w.flags_in = flags;
    w.count_nonzero = cnz;
    return w;
  endfunction

  function automatic in_word_t random_word(input int op_hi);
    return make_word(op_t'($urandom_range(0, op_hi)), 8'($urandom), 8'($urandom),
                     1'($urandom));
  endfunction

  // Offer one word, hold it until taken, then, unless sending steadily, idle between bursts.
  task automatic send_word(input in_word_t w);
    cmd <= w;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ready) @(posedge clk);
    pending_results.push_back(apply_acc_op(w));
    if (!steady_send) begin
      if (burst_left == 0) begin
        cmd_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 8);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(make_word(OP_LOAD, 8'h9a, 8'h00, 1'b0));
    send_word(make_word(OP_DAA, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_LOAD, 8'h15, 8'h13, 1'b1));
    send_word(make_word(OP_DAA, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_CPL, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_LOAD, 8'h80, 8'hff, 1'b0));
    send_word(make_word(OP_RLCA, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_RRCA, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_RLA, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_RRA, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_SCF, 8'h00, 8'h00, 1'b0));
    // X and Y set in F with Q clear, so SCF keeps them
    send_word(make_word(OP_LOAD, 8'h00, 8'h28, 1'b0));
    send_word(make_word(OP_SCF, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_CCF, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_NOFLAG, 8'hff, 8'hff, 1'b1));
    send_word(make_word(OP_CCF, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_RLD, 8'hff, 8'h00, 1'b0));
    send_word(make_word(OP_RRD, 8'h00, 8'h00, 1'b0));
    send_word(make_word(OP_LOAD, 8'h3c, 8'h00, 1'b0));
    send_word(make_word(OP_CPI, 8'h3c, 8'h00, 1'b0));
    send_word(make_word(OP_CPI, 8'h0d, 8'h00, 1'b1));
    send_word(make_word(OP_LDI, 8'hff, 8'h00, 1'b1));
    send_word(make_word(OP_LDI, 8'h00, 8'hff, 1'b0));
    send_word(make_word(OP_RSV0, 8'h5a, 8'ha5, 1'b1));
    send_word(make_word(OP_RSV1, 8'ha5, 8'h5a, 1'b0));
  endtask

  task automatic test_random_words(input int count);
    repeat (count) send_word(random_word(15));
  endtask

  // Load A and F, then run a short string of flag operations on them.
  task automatic test_load_sequences(input int count);
    repeat (count) begin
      send_word(make_word(OP_LOAD, 8'($urandom), 8'($urandom), 1'($urandom)));
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 3) == 0)
          send_word(make_word(OP_DAA, 8'($urandom), 8'($urandom), 1'($urandom)));
        else
          send_word(random_word(12));
      end
    end
  endtask

  // Stall the result side while words keep coming, so the input backs up.
  task automatic test_result_backpressure();
    steady_send = 1'b1;
    hold_seq <= hold_seq + 1;
    repeat (30) send_word(random_word(15));
    steady_send = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (40) send_word(random_word(15));
    wait_drained();
    repeat (40) send_word(random_word(15));
  endtask

  // Result side: a long hold on request, else a rotating ready pattern.
  initial begin : result_side
    int         hold_seen;
    int         hold_left;
    int         pat_left;
    logic [7:0] stall_pat;
    logic [2:0] pat_pos;
    hold_seen = 0;
    hold_left = 0;
    pat_left = 0;
    stall_pat = 8'hff;
    pat_pos = '0;
    res_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ready <= 1'b0;
      end else begin
        if (pat_left == 0) begin
          pat_left = $urandom_range(16, 96);
          stall_pat = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
        end
        pat_left--;
        res_ready <= stall_pat[pat_pos];
        pat_pos = pat_pos + 3'd1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected result: acc %h flags %h mem %h q %b",
                   res.acc, res.flag_byte, res.mem_byte, res.q_out);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (res.acc !== want.acc || res.flag_byte !== want.flag_byte ||
            res.mem_byte !== want.mem_byte || res.q_out !== want.q_out) begin
          if (mismatch_count < 10)
            $display("mismatch: acc %h/%h flags %h/%h mem %h/%h q %b/%b (exp/got)",
                     want.acc, res.acc, want.flag_byte, res.flag_byte,
                     want.mem_byte, res.mem_byte, want.q_out, res.q_out);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd = '0;
    mismatch_count = 0;
    cycle_count = 0;
    burst_left = 0;
    steady_send = 1'b0;
    hold_seq = 0;
    acc_model = '0;
    flag_model = '0;
    touched_model = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_words(700);
    test_result_backpressure();
    test_drain_pause();
    test_load_sequences(270);
    test_random_words(200);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
